### hdl/hre_pkg.sv
`timescale 1ns / 1ps
package hre_pkg;

    localparam int MAX_STATES  = 16;
    localparam int MAX_SYMBOLS = 32;
    localparam int ACC_WIDTH   = 32;
    localparam int FRAC_BITS   = 16;

    localparam int ST_W    = $clog2(MAX_STATES);
    localparam int SYM_W   = $clog2(MAX_SYMBOLS);
    localparam int TR_AW   = 2 * ST_W;
    localparam int EM_AW   = ST_W + SYM_W;
    localparam int NUM_W   = ACC_WIDTH + 2;
    localparam int DEN_W   = ACC_WIDTH + 6;
    localparam int VAL_W   = 16;
    localparam int FIRST_W = 16;
    localparam int TOTAL_W = 20;
    localparam int CNT_W   = $clog2(FRAC_BITS + 1);

    typedef enum logic [1:0] {
        FUNC_GAMMA = 2'd0,
        FUNC_XI    = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        TBL_INIT  = 2'd0,
        TBL_TRANS = 2'd1,
        TBL_EMIS  = 2'd2
    } t_table;

    typedef enum logic [1:0] {
        CFG_EPSILON = 2'd0,
        CFG_STATES  = 2'd1,
        CFG_SYMBOLS = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_SUM,
        S_DIV
    } t_state;

    typedef struct packed {
        logic             start;
        logic             bad;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
        logic             zero;
    } t_div_rsp;

    function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [ACC_WIDTH-1:0] a,
                                                     input logic [15:0] b);
        logic [ACC_WIDTH:0] s;
        s = {1'b0, a} + (ACC_WIDTH + 1)'(b);
        return s[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : s[ACC_WIDTH-1:0];
    endfunction

endpackage

### hdl/hmm_reestimation_flattened_top.sv
`timescale 1ns / 1ps
// Baum-Welch M-step accumulator for a discrete HMM. Gamma and xi items each do
// one read-modify-write of the emission or transition count memory; a query
// goes through the read, multiply and sum states and then the bit-serial divider,
// one quotient bit a cycle, and then the output register. Clear items and reset
// start a sweep over the 512 emission addresses that zeroes the
// emission memory (the transition memory is zeroed alongside); no item is
// accepted during the sweep, configuration writes are. Results come one per
// query, saturated at 65535, with zero_divisor set when an in-range query's normalizer was 0.
module hmm_reestimation_flattened_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [1:0]  i_table_req,
    input  logic [3:0]  i_state_i,
    input  logic [3:0]  i_state_j,
    input  logic [4:0]  i_symbol,
    input  logic [15:0] i_prob,
    input  logic        i_is_first_step,
    input  logic        i_is_last_step,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_value,
    output logic        o_zero_divisor,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = hre_pkg::ACC_WIDTH;

    hre_pkg::t_state r_state, n_state;

    logic [15:0] r_eps;
    logic [4:0]  r_nst;
    logic [5:0]  r_nsym;
    logic [4:0]  w_ni;
    logic [5:0]  w_nm;

    logic [hre_pkg::FIRST_W-1:0] r_first [hre_pkg::MAX_STATES];
    logic [hre_pkg::TOTAL_W-1:0] r_ftot;
    logic [AW-1:0]               r_head  [hre_pkg::MAX_STATES];
    logic [AW-1:0]               r_whole [hre_pkg::MAX_STATES];
    logic [AW-1:0]               r_row   [hre_pkg::MAX_STATES];

    hre_pkg::t_func            r_func;
    logic [1:0]                r_tbl;
    logic [hre_pkg::ST_W-1:0]  r_si, r_sj;
    logic [hre_pkg::SYM_W-1:0] r_sym;
    logic [15:0]               r_prob;
    logic                      r_first_f, r_last_f, r_ok;
    logic [AW-1:0]             r_cnt;
    logic [AW-1:0]             r_p_hi, r_p_lo;
    logic [AW:0]               r_e;
    logic [hre_pkg::EM_AW-1:0] r_clr_addr;

    logic r_out_valid;
    logic [15:0] r_value;
    logic r_zero;

    logic w_accept, w_ok, w_em_we, w_tr_we, w_ack;
    logic [hre_pkg::EM_AW-1:0] w_em_waddr, w_em_raddr;
    logic [hre_pkg::TR_AW-1:0] w_tr_waddr, w_tr_raddr;
    logic [AW-1:0] w_em_wdata, w_tr_wdata, w_em_rdata, w_tr_rdata;
    logic [AW:0]   w_mul_arg;
    logic [hre_pkg::DEN_W-1:0] w_prod;
    logic [16:0]   w_first_sum;
    logic [hre_pkg::TOTAL_W:0] w_ftot_sum;

    hre_pkg::t_div_req w_req;
    hre_pkg::t_div_rsp w_rsp;

    assign w_ni = (r_nst == '0) ? 5'd1
                : (r_nst > 5'(hre_pkg::MAX_STATES)) ? 5'(hre_pkg::MAX_STATES) : r_nst;
    assign w_nm = (r_nsym == '0) ? 6'd1
                : (r_nsym > 6'(hre_pkg::MAX_SYMBOLS)) ? 6'(hre_pkg::MAX_SYMBOLS) : r_nsym;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (hre_pkg::t_func'(i_func))
            hre_pkg::FUNC_GAMMA: w_ok = ({1'b0, i_state_i} < w_ni)
                                        && ({1'b0, i_symbol} < w_nm);
            hre_pkg::FUNC_XI:    w_ok = ({1'b0, i_state_i} < w_ni)
                                        && ({1'b0, i_state_j} < w_ni);
            hre_pkg::FUNC_QUERY: begin
                if (i_table_req == hre_pkg::TBL_INIT) begin
                    w_ok = {1'b0, i_state_i} < w_ni;
                end else if (i_table_req == hre_pkg::TBL_TRANS) begin
                    w_ok = ({1'b0, i_state_i} < w_ni) && ({1'b0, i_state_j} < w_ni);
                end else if (i_table_req == hre_pkg::TBL_EMIS) begin
                    w_ok = ({1'b0, i_state_i} < w_ni) && ({1'b0, i_symbol} < w_nm);
                end else begin
                    w_ok = 1'b0;
                end
            end
            default:             w_ok = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hre_pkg::S_CLEAR: if (r_clr_addr == '1) n_state = hre_pkg::S_IDLE;
            hre_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (hre_pkg::t_func'(i_func) == hre_pkg::FUNC_CLEAR)
                            ? hre_pkg::S_CLEAR : hre_pkg::S_READ;
                end
            end
            hre_pkg::S_READ: begin
                n_state = (r_func == hre_pkg::FUNC_QUERY) ? hre_pkg::S_MUL
                                                          : hre_pkg::S_IDLE;
            end
            hre_pkg::S_MUL:  n_state = hre_pkg::S_SUM;
            hre_pkg::S_SUM:  n_state = hre_pkg::S_DIV;
            hre_pkg::S_DIV:  if (w_ack) n_state = hre_pkg::S_IDLE;
            default:         n_state = hre_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_stall = r_state != hre_pkg::S_IDLE;
        w_em_raddr = {i_state_i, i_symbol};
        w_tr_raddr = {i_state_i, i_state_j};
        w_em_we    = 1'b0;
        w_tr_we    = 1'b0;
        w_em_waddr = {r_si, r_sym};
        w_tr_waddr = {r_si, r_sj};
        w_em_wdata = hre_pkg::sat_acc(w_em_rdata, r_prob);
        w_tr_wdata = hre_pkg::sat_acc(w_tr_rdata, r_prob);
        unique case (r_state)
            hre_pkg::S_CLEAR: begin
                w_em_we    = 1'b1;
                w_tr_we    = 1'b1;
                w_em_waddr = r_clr_addr;
                w_tr_waddr = r_clr_addr[hre_pkg::TR_AW-1:0];
                w_em_wdata = '0;
                w_tr_wdata = '0;
            end
            hre_pkg::S_READ: begin
                w_em_we = r_ok && (r_func == hre_pkg::FUNC_GAMMA);
                w_tr_we = r_ok && (r_func == hre_pkg::FUNC_XI);
            end
            default: ;
        endcase
    end

    assign w_mul_arg   = (r_tbl == hre_pkg::TBL_TRANS) ? r_e : (AW + 1)'(r_eps);
    assign w_prod      = hre_pkg::DEN_W'(w_ni * w_mul_arg);
    assign w_first_sum = {1'b0, r_first[r_si]} + 17'(r_prob);
    assign w_ftot_sum  = {1'b0, r_ftot} + (hre_pkg::TOTAL_W + 1)'(r_prob);

    always_comb begin
        w_req.start = r_state == hre_pkg::S_SUM;
        w_req.bad   = !r_ok;
        if (r_tbl == hre_pkg::TBL_TRANS) begin
            w_req.num = hre_pkg::NUM_W'(r_e) + hre_pkg::NUM_W'(r_cnt);
            w_req.den = w_prod + hre_pkg::DEN_W'(r_row[r_si]);
        end else if (r_tbl == hre_pkg::TBL_INIT) begin
            w_req.num = hre_pkg::NUM_W'(r_eps) + hre_pkg::NUM_W'(r_first[r_si]);
            w_req.den = w_prod + hre_pkg::DEN_W'(r_ftot);
        end else begin
            w_req.num = hre_pkg::NUM_W'(r_eps) + hre_pkg::NUM_W'(r_cnt);
            w_req.den = hre_pkg::DEN_W'(r_whole[r_si]);
        end
    end

    assign w_ack = (r_state == hre_pkg::S_DIV) && w_rsp.done
                   && (!r_out_valid || !i_out_stall);

    hre_ram #(.WIDTH(AW), .DEPTH(hre_pkg::MAX_STATES * hre_pkg::MAX_SYMBOLS)) u_em_ram (
        .i_clk   (i_clk),
        .i_we    (w_em_we),
        .i_waddr (w_em_waddr),
        .i_wdata (w_em_wdata),
        .i_raddr (w_em_raddr),
        .o_rdata (w_em_rdata)
    );

    hre_ram #(.WIDTH(AW), .DEPTH(hre_pkg::MAX_STATES * hre_pkg::MAX_STATES)) u_tr_ram (
        .i_clk   (i_clk),
        .i_we    (w_tr_we),
        .i_waddr (w_tr_waddr),
        .i_wdata (w_tr_wdata),
        .i_raddr (w_tr_raddr),
        .o_rdata (w_tr_rdata)
    );

    hre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_ack   (w_ack),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hre_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_eps       <= '0;
            r_nst       <= 5'(hre_pkg::MAX_STATES);
            r_nsym      <= 6'(hre_pkg::MAX_SYMBOLS);
            r_out_valid <= 1'b0;
            r_ftot      <= '0;
            for (int k = 0; k < hre_pkg::MAX_STATES; k++) begin
                r_first[k] <= '0;
                r_head[k]  <= '0;
                r_whole[k] <= '0;
                r_row[k]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (hre_pkg::t_cfg_idx'(i_cfg_index))
                    hre_pkg::CFG_EPSILON: r_eps  <= i_cfg_data;
                    hre_pkg::CFG_STATES:  r_nst  <= i_cfg_data[4:0];
                    hre_pkg::CFG_SYMBOLS: r_nsym <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (r_state == hre_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_accept && hre_pkg::t_func'(i_func) == hre_pkg::FUNC_CLEAR) begin
                // zero the flop sums now; the memories follow in the sweep
                r_clr_addr <= '0;
                r_ftot     <= '0;
                for (int k = 0; k < hre_pkg::MAX_STATES; k++) begin
                    r_first[k] <= '0;
                    r_head[k]  <= '0;
                    r_whole[k] <= '0;
                    r_row[k]   <= '0;
                end
            end
            if (r_state == hre_pkg::S_READ && r_ok) begin
                if (r_func == hre_pkg::FUNC_GAMMA) begin
                    if (r_first_f) begin
                        r_first[r_si] <= w_first_sum[16] ? '1 : w_first_sum[15:0];
                        r_ftot <= w_ftot_sum[hre_pkg::TOTAL_W] ? '1
                                : w_ftot_sum[hre_pkg::TOTAL_W-1:0];
                    end
                    if (!r_last_f) begin
                        r_head[r_si] <= hre_pkg::sat_acc(r_head[r_si], r_prob);
                    end
                    r_whole[r_si] <= hre_pkg::sat_acc(r_whole[r_si], r_prob);
                end else if (r_func == hre_pkg::FUNC_XI) begin
                    r_row[r_si] <= hre_pkg::sat_acc(r_row[r_si], r_prob);
                end
            end
            if (w_ack) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_func    <= hre_pkg::t_func'(i_func);
            r_tbl     <= i_table_req;
            r_si      <= i_state_i;
            r_sj      <= i_state_j;
            r_sym     <= i_symbol;
            r_prob    <= i_prob;
            r_first_f <= i_is_first_step;
            r_last_f  <= i_is_last_step;
            r_ok      <= w_ok;
        end
        if (r_state == hre_pkg::S_READ) begin
            r_cnt  <= (r_tbl == hre_pkg::TBL_TRANS) ? w_tr_rdata : w_em_rdata;
            r_p_hi <= AW'(r_eps * r_head[r_si][AW-1:16]);
            r_p_lo <= AW'(r_eps * r_head[r_si][15:0]);
        end
        if (r_state == hre_pkg::S_MUL) begin
            r_e <= {1'b0, r_p_hi} + (AW + 1)'(r_p_lo[31:16]);
        end
        if (w_ack) begin
            r_value <= w_rsp.value;
            r_zero  <= w_rsp.zero;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_zero_divisor = r_zero;

`ifndef SYNTH
    a_zero_flag_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_divisor |-> o_value == '0)
        else $error("zero divisor flagged with nonzero value");
    a_clear_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_func == hre_pkg::FUNC_CLEAR |=> r_state == hre_pkg::S_CLEAR)
        else $error("clear item did not start the sweep");
    a_mem_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_em_we || w_tr_we |-> r_state == hre_pkg::S_READ || r_state == hre_pkg::S_CLEAR)
        else $error("memory write outside update or sweep");
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.done)
        else $error("divider started while a result is pending");
`endif

endmodule

### hdl/hre_ram.sv
`timescale 1ns / 1ps
module hre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/hre_div.sv
`timescale 1ns / 1ps
module hre_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hre_pkg::t_div_req i_req,
    input  logic              i_ack,
    output hre_pkg::t_div_rsp o_rsp
);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [hre_pkg::DEN_W-1:0]       r_rem, n_rem;
    logic [hre_pkg::DEN_W-1:0]       r_den, n_den;
    logic [hre_pkg::VAL_W-1:0]       r_q, n_q;
    logic                            r_zero, n_zero;
    logic [hre_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [hre_pkg::DEN_W:0]         w_shift;
    logic                            w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        n_zero = r_zero;
        n_cnt  = r_cnt;
        if (r_done && i_ack) begin
            n_done = 1'b0;
        end
        if (i_req.start && !r_busy && !r_done) begin
            n_zero = 1'b0;
            n_q    = '0;
            n_rem  = hre_pkg::DEN_W'(i_req.num);
            n_den  = i_req.den;
            n_cnt  = '0;
            priority if (i_req.bad) begin
                n_done = 1'b1;
            end else if (i_req.den == '0) begin
                n_zero = 1'b1;
                n_done = 1'b1;
            end else if (hre_pkg::DEN_W'(i_req.num) >= i_req.den) begin
                n_q    = '1;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            // one quotient bit per cycle
            n_rem = w_ge ? hre_pkg::DEN_W'(w_shift - {1'b0, r_den})
                         : hre_pkg::DEN_W'(w_shift);
            n_q   = {r_q[hre_pkg::VAL_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == hre_pkg::CNT_W'(hre_pkg::FRAC_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
        r_zero <= n_zero;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_q;
    assign o_rsp.zero  = r_zero;

`ifndef SYNTH
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done)) else $error("divider busy and done together");
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_zero |-> r_q == '0) else $error("zero divisor with nonzero value");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < r_den) else $error("remainder not below divisor");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        hre_pkg::t_func func;
        logic [1:0]  tbl;
        logic [3:0]  si;
        logic [3:0]  sj;
        logic [4:0]  sym;
        logic [15:0] prob;
        logic        first;
        logic        last;
        logic        typed;
        logic [15:0] exp_value;
        logic        exp_zero;
    } t_row;

    typedef struct {
        logic [15:0] value;
        logic        zero;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_func;
    logic [1:0]  i_table_req;
    logic [3:0]  i_state_i;
    logic [3:0]  i_state_j;
    logic [4:0]  i_symbol;
    logic [15:0] i_prob;
    logic        i_is_first_step;
    logic        i_is_last_step;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_value;
    logic        o_zero_divisor;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    hmm_reestimation_flattened_top dut (.*);

    // model of the sums and registers
    logic [15:0] eps;
    logic [4:0]  nstates_reg;
    logic [5:0]  nsymbols_reg;
    logic [15:0] g_first [hre_pkg::MAX_STATES];
    logic [19:0] g_first_total;
    logic [31:0] g_head [hre_pkg::MAX_STATES];
    logic [31:0] g_whole [hre_pkg::MAX_STATES];
    logic [31:0] xi_count [hre_pkg::MAX_STATES*hre_pkg::MAX_STATES];
    logic [31:0] xi_row [hre_pkg::MAX_STATES];
    logic [31:0] sym_count [hre_pkg::MAX_STATES*hre_pkg::MAX_SYMBOLS];

    t_answer     pending_answers [$];
    int          errors = 0;
    bit          quiet = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic [63:0] sat(input logic [63:0] a, input logic [63:0] b,
                                        input logic [63:0] cap);
        logic [63:0] s;
        s = a + b;
        return (s > cap) ? cap : s;
    endfunction

    function automatic int states_in_use();
        if (nstates_reg == 0) return 1;
        return (nstates_reg > hre_pkg::MAX_STATES) ? hre_pkg::MAX_STATES : int'(nstates_reg);
    endfunction

    function automatic int symbols_in_use();
        if (nsymbols_reg == 0) return 1;
        return (nsymbols_reg > hre_pkg::MAX_SYMBOLS) ? hre_pkg::MAX_SYMBOLS
                                                     : int'(nsymbols_reg);
    endfunction

    function automatic t_answer ratio(input logic [63:0] num, input logic [63:0] den);
        t_answer a;
        logic [63:0] q;
        a.zero = 0;
        a.value = 0;
        if (den == 0) begin
            a.zero = 1;
            return a;
        end
        q = (num << hre_pkg::FRAC_BITS) / den;
        a.value = (q > 65535) ? 16'hFFFF : q[15:0];
        return a;
    endfunction

    task automatic wipe_sums();
        g_first_total = 0;
        for (int k = 0; k < hre_pkg::MAX_STATES; k++) begin
            g_first[k] = 0;
            g_head[k] = 0;
            g_whole[k] = 0;
            xi_row[k] = 0;
        end
        foreach (xi_count[k]) xi_count[k] = 0;
        foreach (sym_count[k]) sym_count[k] = 0;
    endtask

    // update the sums for one accepted item; queue the answer of a query
    task automatic reestimate(input t_row r);
        int ni;
        int nm;
        logic [63:0] g;
        logic [63:0] e;
        t_answer a;
        ni = states_in_use();
        nm = symbols_in_use();
        case (r.func)
            hre_pkg::FUNC_GAMMA: begin
                if (r.si < ni && r.sym < nm) begin
                    if (r.first) begin
                        g_first[r.si] = 16'(sat(g_first[r.si], r.prob, 64'hFFFF));
                        g_first_total = 20'(sat(g_first_total, r.prob, 64'hFFFFF));
                    end
                    if (!r.last)
                        g_head[r.si] = 32'(sat(g_head[r.si], r.prob, 64'hFFFF_FFFF));
                    g_whole[r.si] = 32'(sat(g_whole[r.si], r.prob, 64'hFFFF_FFFF));
                    sym_count[r.si*hre_pkg::MAX_SYMBOLS + r.sym] =
                        32'(sat(sym_count[r.si*hre_pkg::MAX_SYMBOLS + r.sym], r.prob,
                                64'hFFFF_FFFF));
                end
            end
            hre_pkg::FUNC_XI: begin
                if (r.si < ni && r.sj < ni) begin
                    xi_count[r.si*hre_pkg::MAX_STATES + r.sj] =
                        32'(sat(xi_count[r.si*hre_pkg::MAX_STATES + r.sj], r.prob,
                                64'hFFFF_FFFF));
                    xi_row[r.si] = 32'(sat(xi_row[r.si], r.prob, 64'hFFFF_FFFF));
                end
            end
            hre_pkg::FUNC_CLEAR: wipe_sums();
            default: begin
                a.value = 0;
                a.zero = 0;
                if (r.tbl == hre_pkg::TBL_INIT) begin
                    if (r.si < ni)
                        a = ratio(64'(eps) + g_first[r.si],
                                  64'(ni) * eps + g_first_total);
                end else if (r.tbl == hre_pkg::TBL_TRANS) begin
                    if (r.si < ni && r.sj < ni) begin
                        g = g_head[r.si];
                        e = 64'(eps) * (g >> 16) + ((64'(eps) * (g & 64'hFFFF)) >> 16);
                        a = ratio(e + xi_count[r.si*hre_pkg::MAX_STATES + r.sj],
                                  64'(ni) * e + xi_row[r.si]);
                    end
                end else if (r.tbl == hre_pkg::TBL_EMIS) begin
                    if (r.si < ni && r.sym < nm)
                        a = ratio(64'(eps) + sym_count[r.si*hre_pkg::MAX_SYMBOLS + r.sym],
                                  g_whole[r.si]);
                end
                if (r.typed) begin
                    a.value = r.exp_value;
                    a.zero = r.exp_zero;
                end
                pending_answers.push_back(a);
            end
        endcase
    endtask

    // result side: random stall bursts, compare against the oldest answer
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_answer a;
        if (o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result value=%0d zero=%0b",
                                           o_value, o_zero_divisor);
            end else begin
                a = pending_answers.pop_front();
                if (o_value !== a.value || o_zero_divisor !== a.zero) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected value=%0d zero=%0b, got value=%0d zero=%0b",
                                 a.value, a.zero, o_value, o_zero_divisor);
                end
            end
        end
        if (!i_rst_n || quiet) begin
            i_out_stall <= 0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= (stall_left > 0);
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 8);
            i_out_stall <= 1;
        end else begin
            i_out_stall <= 0;
        end
    end

    // call just after a rising edge; returns at or after the accepting edge
    task automatic send(input t_row r);
        int gap;
        i_in_valid <= 1;
        i_func <= r.func;
        i_table_req <= r.tbl;
        i_state_i <= r.si;
        i_state_j <= r.sj;
        i_symbol <= r.sym;
        i_prob <= r.prob;
        i_is_first_step <= r.first;
        i_is_last_step <= r.last;
        do @(posedge i_clk); while (o_in_stall);
        reestimate(r);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input hre_pkg::t_cfg_idx idx, input logic [15:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            hre_pkg::CFG_EPSILON: eps = data;
            hre_pkg::CFG_STATES: nstates_reg = data[4:0];
            default: nsymbols_reg = data[5:0];
        endcase
    endtask

    // drain, let the block settle, then load a new setting
    task automatic configure(input logic [15:0] e, input logic [15:0] ns,
                             input logic [15:0] nm);
        i_in_valid <= 0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        write_reg(hre_pkg::CFG_EPSILON, e);
        write_reg(hre_pkg::CFG_STATES, ns);
        write_reg(hre_pkg::CFG_SYMBOLS, nm);
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_prob();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] pick_state();
        if ($urandom_range(0, 9) < 8) return 4'($urandom_range(0, states_in_use() - 1));
        return 4'($urandom);
    endfunction

    function automatic logic [4:0] pick_symbol();
        if ($urandom_range(0, 9) < 8) return 5'($urandom_range(0, symbols_in_use() - 1));
        return 5'($urandom);
    endfunction

    function automatic t_row random_row();
        t_row r;
        int pick;
        pick = $urandom_range(0, 99);
        r.func = (pick < 45) ? hre_pkg::FUNC_GAMMA : (pick < 70) ? hre_pkg::FUNC_XI :
                 (pick < 98) ? hre_pkg::FUNC_QUERY : hre_pkg::FUNC_CLEAR;
        r.tbl = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        r.si = pick_state();
        r.sj = pick_state();
        r.sym = pick_symbol();
        r.prob = pick_prob();
        r.first = ($urandom_range(0, 3) == 0);
        r.last = ($urandom_range(0, 3) == 0);
        r.typed = 0;
        r.exp_value = 0;
        r.exp_zero = 0;
        return r;
    endfunction

    function automatic t_row mk(input hre_pkg::t_func f, input logic [1:0] tb,
                                input logic [3:0] si,
                                input logic [3:0] sj, input logic [4:0] sym,
                                input logic [15:0] p, input logic fs, input logic ls,
                                input logic typed, input logic [15:0] ev, input logic ez);
        t_row r;
        r.func = f; r.tbl = tb; r.si = si; r.sj = sj; r.sym = sym; r.prob = p;
        r.first = fs; r.last = ls; r.typed = typed; r.exp_value = ev; r.exp_zero = ez;
        return r;
    endfunction

    t_row directed [$];

    initial begin
        logic [15:0] cfg_set [6][3];
        i_rst_n = 0;
        i_in_valid = 0;
        i_func = hre_pkg::FUNC_GAMMA;
        i_table_req = hre_pkg::TBL_INIT;
        i_state_i = 0;
        i_state_j = 0;
        i_symbol = 0;
        i_prob = 0;
        i_is_first_step = 0;
        i_is_last_step = 0;
        i_out_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = hre_pkg::CFG_EPSILON;
        i_cfg_data = 0;
        eps = 0;
        nstates_reg = 16;
        nsymbols_reg = 32;
        wipe_sums();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // empty sums with epsilon 0: every normalizer is zero
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_INIT, 0, 0, 0, 0, 0, 0,
                              1, 0, 1));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_TRANS, 15, 15, 0, 0, 0, 0,
                              1, 0, 1));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_EMIS, 15, 0, 31, 0, 0, 0,
                              1, 0, 1));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, 2'd3, 3, 3, 3, 0, 0, 0, 1, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_GAMMA, 0, 0, 0, 0, 16'hFFFF, 1, 0, 0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_GAMMA, 0, 0, 0, 0, 16'hFFFF, 1, 1, 0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_GAMMA, 0, 15, 0, 31, 16'h8000, 0, 1, 0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_GAMMA, 0, 15, 0, 31, 16'h0001, 1, 0, 0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_XI, 0, 0, 15, 0, 16'hFFFF, 0, 0, 0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_XI, 0, 15, 0, 0, 16'h0000, 0, 0, 0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_XI, 0, 0, 0, 0, 16'h1234, 0, 0, 0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_INIT, 0, 0, 0, 0, 0, 0,
                              0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_INIT, 15, 0, 0, 0, 0, 0,
                              0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_TRANS, 0, 15, 0, 0, 0, 0,
                              0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_TRANS, 0, 0, 0, 0, 0, 0,
                              0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_EMIS, 0, 0, 0, 0, 0, 0,
                              0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_EMIS, 15, 0, 31, 0, 0, 0,
                              0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_EMIS, 1, 0, 5, 0, 0, 0,
                              1, 0, 1));
        directed.push_back(mk(hre_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_INIT, 0, 0, 0, 0, 0, 0,
                              1, 0, 1));
        directed.push_back(mk(hre_pkg::FUNC_QUERY, hre_pkg::TBL_EMIS, 0, 0, 0, 0, 0, 0,
                              1, 0, 1));

        @(posedge i_clk);
        foreach (directed[k]) send(directed[k]);

        cfg_set = '{'{16'hFFFF, 1, 1}, '{16'd1000, 4, 5}, '{16'd300, 0, 0},
                    '{16'hFFFF, 31, 63}, '{16'd0, 16, 32}, '{16'd77, 9, 20}};
        for (int ph = 0; ph < 6; ph++) begin
            configure(cfg_set[ph][0], cfg_set[ph][1], cfg_set[ph][2]);
            if (ph == 5) quiet = 1;
            for (int n = 0; n < 125; n++) send(random_row());
        end

        i_in_valid <= 0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
